// ===== rtl/core/psa_pkg.sv =====
package psa_pkg;

	// Widths of the pixel bytes and of the gain register.
	localparam int PIX_W  = 8;
	localparam int GAIN_W = 11;

	// Gain of 1.0 in Q3.8; this is also the reset value of the register.
	localparam logic [GAIN_W-1:0] GAIN_ONE = 11'd256;

	// Luma weights; their sum is 256, so the luma always fits in one byte.
	localparam int LUMA_SUM_W = 16;
	localparam logic [LUMA_SUM_W-1:0] LUMA_WEIGHT_B = 16'd28;
	localparam logic [LUMA_SUM_W-1:0] LUMA_WEIGHT_G = 16'd151;
	localparam logic [LUMA_SUM_W-1:0] LUMA_WEIGHT_R = 16'd77;

	// Signed difference c - luma, the product with the gain, and the full mix.
	localparam int DIFF_W = PIX_W + 1;
	localparam int PROD_W = DIFF_W + GAIN_W + 1;
	localparam int MIX_W  = PROD_W + 1;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [GAIN_W-1:0] gain_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Load enables of the three pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} psa_adv_t;

endpackage

// ===== rtl/core/pixel_saturation_adjust.sv =====
// Saturation adjustment of a BGRA pixel stream. Each beat carries one pixel;
// the block computes its luma and moves every color channel toward it or away
// from it by the Q3.8 gain in cfg_wdata (256 leaves the pixel as it is, 0 gives
// gray, larger values strengthen the colors), clamping each channel to 0..255.
// Alpha passes through. The pipeline has three register stages: luma, gain
// product, and add with clamp into the output register, and one pixel is
// taken every cycle as long as the output is not stalled. A stall on the
// output reaches the input only once the bubbles in the pipeline are used
// up. Write the gain only while no pixel is in flight.
module pixel_saturation_adjust (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  psa_pkg::gain_t        cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  psa_pkg::pix_t         in_blue,
	input  psa_pkg::pix_t         in_green,
	input  psa_pkg::pix_t         in_red,
	input  psa_pkg::pix_t         in_alpha,
	output logic                  out_valid,
	input  logic                  out_stall,
	output psa_pkg::pix_t         out_blue,
	output psa_pkg::pix_t         out_green,
	output psa_pkg::pix_t         out_red,
	output psa_pkg::pix_t         out_alpha
);

	psa_pkg::gain_t    gain_q;
	psa_pkg::psa_adv_t adv;
	logic              adv1;
	logic              adv2;
	logic              adv3;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	psa_pkg::pix_t     luma_s1;
	psa_pkg::pix_t     blue_s1;
	psa_pkg::pix_t     green_s1;
	psa_pkg::pix_t     red_s1;
	psa_pkg::pix_t     alpha_s1;
	psa_pkg::pix_t     alpha_s2;
	psa_pkg::pix_t     alpha_s3;

	// Gain register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= psa_pkg::GAIN_ONE;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// A stage loads when it is empty or when the stage after it moves on.
	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign adv      = '{s1: adv1, s2: adv2, s3: adv3};
	assign in_stall = !adv1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv.s1) begin
				valid_s1 <= in_valid;
			end
			if (adv.s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv.s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Alpha is only delayed to stay aligned with the colors.
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			alpha_s1 <= in_alpha;
		end
		if (adv.s2) begin
			alpha_s2 <= alpha_s1;
		end
		if (adv.s3) begin
			alpha_s3 <= alpha_s2;
		end
	end

	psa_luma u_luma (
		.clk      (clk),
		.adv      (adv),
		.blue     (in_blue),
		.green    (in_green),
		.red      (in_red),
		.luma_s1  (luma_s1),
		.blue_s1  (blue_s1),
		.green_s1 (green_s1),
		.red_s1   (red_s1)
	);

	psa_chan u_chan_blue (
		.clk       (clk),
		.adv       (adv),
		.gain      (gain_q),
		.color_s1  (blue_s1),
		.luma_s1   (luma_s1),
		.result_s3 (out_blue)
	);

	psa_chan u_chan_green (
		.clk       (clk),
		.adv       (adv),
		.gain      (gain_q),
		.color_s1  (green_s1),
		.luma_s1   (luma_s1),
		.result_s3 (out_green)
	);

	psa_chan u_chan_red (
		.clk       (clk),
		.adv       (adv),
		.gain      (gain_q),
		.color_s1  (red_s1),
		.luma_s1   (luma_s1),
		.result_s3 (out_red)
	);

	assign out_valid = valid_s3;
	assign out_alpha = alpha_s3;

endmodule

// ===== rtl/core/psa_luma.sv =====
module psa_luma (
	input  logic             clk,
	input  psa_pkg::psa_adv_t adv,
	input  psa_pkg::pix_t     blue,
	input  psa_pkg::pix_t     green,
	input  psa_pkg::pix_t     red,
	output psa_pkg::pix_t     luma_s1,
	output psa_pkg::pix_t     blue_s1,
	output psa_pkg::pix_t     green_s1,
	output psa_pkg::pix_t     red_s1
);

	logic [psa_pkg::LUMA_SUM_W-1:0] luma_sum;

	// Weighted sum of the three colors; the top byte is the luma.
	assign luma_sum = {8'd0, blue}  * psa_pkg::LUMA_WEIGHT_B
	                + {8'd0, green} * psa_pkg::LUMA_WEIGHT_G
	                + {8'd0, red}   * psa_pkg::LUMA_WEIGHT_R;

	// First stage register: luma and the source colors.
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			luma_s1  <= luma_sum[psa_pkg::LUMA_SUM_W-1 -: psa_pkg::PIX_W];
			blue_s1  <= blue;
			green_s1 <= green;
			red_s1   <= red;
		end
	end

endmodule

// ===== rtl/core/psa_chan.sv =====
module psa_chan (
	input  logic              clk,
	input  psa_pkg::psa_adv_t adv,
	input  psa_pkg::gain_t    gain,
	input  psa_pkg::pix_t     color_s1,
	input  psa_pkg::pix_t     luma_s1,
	output psa_pkg::pix_t     result_s3
);

	logic signed [psa_pkg::DIFF_W-1:0] diff;
	psa_pkg::prod_t                    prod_s2;
	psa_pkg::pix_t                     luma_s2;
	logic signed [psa_pkg::MIX_W-1:0]  mix;
	psa_pkg::pix_t                     clamped;

	// The mix c*g + luma*(256-g) is rewritten as luma*256 + (c-luma)*g.
	assign diff = $signed({1'b0, color_s1} - {1'b0, luma_s1});

	// Second stage register: the signed product with the gain.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prod_s2 <= psa_pkg::PROD_W'(diff * $signed({1'b0, gain}));
			luma_s2 <= luma_s1;
		end
	end

	// Add the luma back, scale down by 256 and saturate to one byte.
	assign mix = psa_pkg::MIX_W'(prod_s2)
	           + $signed({{(psa_pkg::MIX_W-2*psa_pkg::PIX_W){1'b0}}, luma_s2,
	                      {psa_pkg::PIX_W{1'b0}}});

	always_comb begin
		if (mix[psa_pkg::MIX_W-1]) begin
			clamped = '0;
		end else if (mix[psa_pkg::MIX_W-2:2*psa_pkg::PIX_W] != '0) begin
			clamped = '1;
		end else begin
			clamped = mix[2*psa_pkg::PIX_W-1:psa_pkg::PIX_W];
		end
	end

	// Third stage register drives the output byte.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			result_s3 <= clamped;
		end
	end

endmodule

// ===== rtl/core/psa_check.sv =====
module psa_check (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input psa_pkg::pix_t  in_alpha,
	input logic           out_valid,
	input logic           out_stall,
	input psa_pkg::pix_t  out_blue,
	input psa_pkg::pix_t  out_green,
	input psa_pkg::pix_t  out_red,
	input psa_pkg::pix_t  out_alpha
);

	// A stalled output beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// A stalled output beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_blue) && $stable(out_green)
			&& $stable(out_red) && $stable(out_alpha))
		else $error("output payload changed while stalled");

	// The input is never stalled while the output flows.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	// With a free output, a taken pixel moves through s1, s2 and s3 and leaves with its own alpha.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall
			|=> out_valid && (out_alpha == $past(in_alpha, 3)))
		else $error("pixel did not leave after three cycles");

endmodule

bind pixel_saturation_adjust psa_check u_psa_check (.*);

// ===== verif/pixel_saturation_checker.sv =====
module pixel_saturation_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  psa_pkg::gain_t cfg_wdata,
	input  logic           in_valid,
	input  logic           in_stall,
	input  psa_pkg::pix_t  in_blue,
	input  psa_pkg::pix_t  in_green,
	input  psa_pkg::pix_t  in_red,
	input  psa_pkg::pix_t  in_alpha,
	input  logic           out_valid,
	input  logic           out_stall,
	input  psa_pkg::pix_t  out_blue,
	input  psa_pkg::pix_t  out_green,
	input  psa_pkg::pix_t  out_red,
	input  psa_pkg::pix_t  out_alpha,
	output int             mismatches,
	output int             pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Luma weights sum to 256, so the luma is always one byte wide.
	localparam int WEIGHT_B    = 28;
	localparam int WEIGHT_G    = 151;
	localparam int WEIGHT_R    = 77;
	localparam int LUMA_SHIFT  = 8;
	localparam int UNITY_GAIN  = 256;
	localparam int FRAC_BITS   = 8;
	localparam int BYTE_MAX    = 255;

	typedef struct packed {
		psa_pkg::pix_t blue;
		psa_pkg::pix_t green;
		psa_pkg::pix_t red;
		psa_pkg::pix_t alpha;
	} pixel_t;

	psa_pkg::gain_t gain_now;
	pixel_t         expected_pixels[$];
	int             error_total;

	assign mismatches = error_total;

	// Mix one channel with the luma by the gain, then floor and clamp to a byte.
	function automatic psa_pkg::pix_t mix_toward_luma(psa_pkg::pix_t chan, int luma,
		psa_pkg::gain_t gain);
		int mix;
		mix = int'(chan) * int'(gain) + luma * (UNITY_GAIN - int'(gain));
		if (mix < 0)
			return '0;
		mix = mix >>> FRAC_BITS;
		if (mix > BYTE_MAX)
			return psa_pkg::pix_t'(BYTE_MAX);
		return psa_pkg::pix_t'(mix);
	endfunction

	// Expected output pixel for one source pixel at the current gain.
	function automatic pixel_t saturate_pixel(pixel_t src, psa_pkg::gain_t gain);
		int     luma;
		pixel_t res;
		luma = (WEIGHT_B * int'(src.blue) + WEIGHT_G * int'(src.green)
			+ WEIGHT_R * int'(src.red)) >> LUMA_SHIFT;
		res.blue  = mix_toward_luma(src.blue, luma, gain);
		res.green = mix_toward_luma(src.green, luma, gain);
		res.red   = mix_toward_luma(src.red, luma, gain);
		res.alpha = src.alpha;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		error_total++;
	endtask

	// Track the gain, queue a prediction per input beat, compare per output beat.
	always @(posedge clk or negedge arst_n) begin
		pixel_t src;
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			gain_now = psa_pkg::GAIN_ONE;
			expected_pixels.delete();
			error_total = 0;
			pending_count <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				src = '{in_blue, in_green, in_red, in_alpha};
				expected_pixels.push_back(saturate_pixel(src, gain_now));
			end
			if (out_valid && !out_stall) begin
				got = '{out_blue, out_green, out_red, out_alpha};
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected output beat", int'(got), 0);
				end else begin
					want = expected_pixels.pop_front();
					if (got.blue !== want.blue)
						report_mismatch("out_blue", int'(got.blue), int'(want.blue));
					if (got.green !== want.green)
						report_mismatch("out_green", int'(got.green), int'(want.green));
					if (got.red !== want.red)
						report_mismatch("out_red", int'(got.red), int'(want.red));
					if (got.alpha !== want.alpha)
						report_mismatch("out_alpha", int'(got.alpha), int'(want.alpha));
				end
			end
			if (cfg_we)
				gain_now = cfg_wdata;
			pending_count <= expected_pixels.size();
		end
	end

endmodule

// ===== verif/tb_pixel_saturation_adjust.sv =====
module tb_pixel_saturation_adjust;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  RESET_CYCLES   = 11;
	localparam int  PIPE_LATENCY   = 3;
	localparam int  HANG_LIMIT     = 5000;
	localparam int  PHASE_COUNT    = 11;
	localparam int  PHASE_PIXELS   = 50;
	localparam psa_pkg::pix_t BYTE_MAX = 8'hFF;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	psa_pkg::gain_t cfg_wdata;
	logic           in_valid;
	logic           in_stall;
	psa_pkg::pix_t  in_blue, in_green, in_red, in_alpha;
	logic           out_valid;
	logic           out_stall;
	psa_pkg::pix_t  out_blue, out_green, out_red, out_alpha;

	int mismatches;
	int pending_count;
	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;

	pixel_saturation_adjust i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_blue   (in_blue),
		.in_green  (in_green),
		.in_red    (in_red),
		.in_alpha  (in_alpha),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_blue  (out_blue),
		.out_green (out_green),
		.out_red   (out_red),
		.out_alpha (out_alpha)
	);

	pixel_saturation_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_blue       (in_blue),
		.in_green      (in_green),
		.in_red        (in_red),
		.in_alpha      (in_alpha),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_blue      (out_blue),
		.out_green     (out_green),
		.out_red       (out_red),
		.out_alpha     (out_alpha),
		.mismatches    (mismatches),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Output side: stall at random with the probability of the current phase.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// End the run if no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("tb_pixel_saturation_adjust: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one pixel after random idle cycles and hold it until it is taken.
	task automatic push_pixel(input psa_pkg::pix_t b, input psa_pkg::pix_t g,
		input psa_pkg::pix_t r, input psa_pkg::pix_t a);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_blue  <= b;
		in_green <= g;
		in_red   <= r;
		in_alpha <= a;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Change the gain only once the pipeline has drained; the first edge lets
	// the count take in the last beat sent.
	task automatic load_gain(input psa_pkg::gain_t gain);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= gain;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		psa_pkg::gain_t phase_gains[PHASE_COUNT];
		psa_pkg::pix_t  b, g, r, a;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		in_valid      <= 1'b0;
		in_blue       <= '0;
		in_green      <= '0;
		in_red        <= '0;
		in_alpha      <= '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels at the reset gain of 1.0: black, white, primaries and one mixed pixel.
		push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		push_pixel(BYTE_MAX, BYTE_MAX, BYTE_MAX, BYTE_MAX);
		push_pixel(BYTE_MAX, 8'h00, 8'h00, 8'h5A);
		push_pixel(8'h00, BYTE_MAX, 8'h00, 8'hA5);
		push_pixel(8'h00, 8'h00, BYTE_MAX, 8'h80);
		push_pixel(8'h01, 8'h80, 8'hFE, 8'h7F);

		// Zero gain turns every pixel gray.
		load_gain(11'd0);
		push_pixel(BYTE_MAX, 8'h00, 8'h00, 8'h11);
		push_pixel(8'h00, 8'h00, BYTE_MAX, 8'h22);
		push_pixel(8'd10, 8'd200, 8'd30, 8'h33);

		// Largest register value: mixes go negative and overflow past a byte.
		load_gain(11'h7FF);
		push_pixel(BYTE_MAX, 8'h00, 8'h00, 8'h44);
		push_pixel(8'h00, BYTE_MAX, 8'h00, 8'h55);
		push_pixel(8'h00, 8'h00, BYTE_MAX, 8'h66);
		push_pixel(8'h80, 8'h80, 8'h80, 8'h77);
		push_pixel(BYTE_MAX, BYTE_MAX, BYTE_MAX, 8'h88);

		// A gain of 4.0.
		load_gain(11'd1024);
		push_pixel(BYTE_MAX, 8'h00, 8'h00, 8'h99);
		push_pixel(8'd200, 8'd100, 8'd50, 8'hAA);
		push_pixel(8'h00, BYTE_MAX, BYTE_MAX, 8'hBB);

		// Phases of random pixels, each with its own gain and one of four idle and stall patterns.
		phase_gains = '{11'd0, 11'd1024, 11'h7FF, 11'd256, 11'd1, 11'd255, 11'd257,
			11'd768, psa_pkg::gain_t'($urandom_range(2047)),
			psa_pkg::gain_t'($urandom_range(1024)),
			psa_pkg::gain_t'($urandom_range(2047))};
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			load_gain(phase_gains[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 54; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 54; end
				default: begin send_idle_pct = 21; stall_pct = 21; end
			endcase
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				b = psa_pkg::pix_t'($urandom);
				g = psa_pkg::pix_t'($urandom);
				r = psa_pkg::pix_t'($urandom);
				a = psa_pkg::pix_t'($urandom);
				case ($urandom_range(9))
					0, 1: begin
						// Gray pixel: luma equals each channel up to rounding.
						g = b;
						r = b;
					end
					2, 3: begin
						// Every channel at an extreme.
						b = $urandom_range(1) ? BYTE_MAX : 8'h00;
						g = $urandom_range(1) ? BYTE_MAX : 8'h00;
						r = $urandom_range(1) ? BYTE_MAX : 8'h00;
					end
					4: begin
						// One strong channel over dark ones, to push the clamps.
						b = psa_pkg::pix_t'($urandom_range(15));
						g = psa_pkg::pix_t'($urandom_range(15));
						r = psa_pkg::pix_t'($urandom_range(15));
						case ($urandom_range(2))
							0: b = BYTE_MAX - psa_pkg::pix_t'($urandom_range(15));
							1: g = BYTE_MAX - psa_pkg::pix_t'($urandom_range(15));
							default: r = BYTE_MAX - psa_pkg::pix_t'($urandom_range(15));
						endcase
					end
					default: ;
				endcase
				push_pixel(b, g, r, a);
			end
		end

		// Drain the pipeline and give the verdict.
		in_valid <= 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 5) @(posedge clk);
		if (mismatches == 0 && pending_count == 0)
			$display("tb_pixel_saturation_adjust: PASS");
		else
			$display("tb_pixel_saturation_adjust: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/psa_pkg.sv
rtl/core/psa_luma.sv
rtl/core/psa_chan.sv
rtl/core/pixel_saturation_adjust.sv
rtl/core/psa_check.sv
verif/pixel_saturation_checker.sv
verif/tb_pixel_saturation_adjust.sv
